@@ design/spqi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spqi_pkg
// Shared codes and control types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spqi_pkg;

   // Operation code carried in the request tuser
   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_CHANGE = 2'd2,
      MODE_POP    = 2'd3
   } mode_type;

   // Result code carried in the response tuser
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Sequencer state: second pass of a priority change
   typedef enum logic {
      S_IDLE     = 1'b0,
      S_REINSERT = 1'b1
   } state_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic ins;  // insert new entry at its sorted place
      logic del;  // close the gap behind the first hit
   } cell_ctrl_type;

   // Width of the entry count field in the response
   localparam int COUNT_FIELD_BITS = 5;

endpackage

@@ design/sorted_priority_queue_with_ids_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_ids_top
// Bounded priority queue of (id, priority) entries kept sorted in a cell row.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the req_ stream: tuser carries the operation (add,
//   remove by id, change priority, pop), tdata the priority and target id.
//   Every request gives exactly one transfer on the rsp_ stream: tuser holds
//   the status, tdata the id, the priority and the entry count afterwards.
//   Entries sit in a row of QUEUE_DEPTH cells sorted by ascending priority,
//   equal priorities in arrival order; each cell swaps data with its
//   neighbors, so insert, remove and pop finish in one pass through the row.
//   The response is registered, valid the cycle after the request transfer;
//   change priority answers after a remove pass and then an insert pass.
//   Throughput: one request per cycle for add, remove and pop while the
//   receiver keeps up; change priority blocks requests during its insert pass.
//   A request is taken while the sequencer is idle and the response register
//   is empty or being drained in the same cycle; when the receiver stalls, one
//   response is held and further requests wait.
//   Reset empties the queue and sets the next id to one; cell contents are
//   not cleared, only the entry count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_ids_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int PRIO_BITS   = 8,
   parameter int ID_BITS     = 16,
   localparam int REQ_W = ((PRIO_BITS + ID_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((ID_BITS + PRIO_BITS + spqi_pkg::COUNT_FIELD_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // prio_in, target_id, zero pad
   input  logic [1:0]       req_tuser,   // mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // result_id, result_prio, entry_count, pad
   output logic [1:0]       rsp_tuser    // status
);
   import spqi_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Control and response registers
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ID_BITS-1:0]   ident_ff, ident_in;
   logic [ID_BITS-1:0]   hold_id_ff, hold_id_in;
   logic [PRIO_BITS-1:0] hold_prio_ff, hold_prio_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]   rsp_id_ff, rsp_id_in;
   logic [PRIO_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [CNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // Request fields
   mode_type             req_mode;
   logic [PRIO_BITS-1:0] req_prio;
   logic [ID_BITS-1:0]   req_target;
   logic                 req_fire;
   logic [ID_BITS-1:0]   ident_inc;

   // Row broadcast and chains
   cell_ctrl_type        ctrl;
   logic [ID_BITS-1:0]   new_id, match_id;
   logic [PRIO_BITS-1:0] new_prio;
   logic                 hit_seed;
   logic [QUEUE_DEPTH:0] le_chain;
   logic [QUEUE_DEPTH:0] hit_chain;
   logic [ID_BITS-1:0]   cell_id   [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0] cell_prio [QUEUE_DEPTH];
   logic                 found;

   assign req_mode   = mode_type'(req_tuser);
   assign req_prio   = req_tdata[PRIO_BITS-1:0];
   assign req_target = req_tdata[PRIO_BITS+ID_BITS-1:PRIO_BITS];
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign ident_inc  = ident_ff + ID_BITS'(1);
   assign found      = hit_chain[QUEUE_DEPTH];

   // Cell row
   assign le_chain[0]  = 1'b1;
   assign hit_chain[0] = hit_seed;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_BITS-1:0]   l_id, r_id;
      logic [PRIO_BITS-1:0] l_prio, r_prio;

      if (i == 0) begin : g_left_end
         assign l_id   = new_id;
         assign l_prio = new_prio;
      end else begin : g_left
         assign l_id   = cell_id[i-1];
         assign l_prio = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_right_end
         assign r_id   = cell_id[i];
         assign r_prio = cell_prio[i];
      end else begin : g_right
         assign r_id   = cell_id[i+1];
         assign r_prio = cell_prio[i+1];
      end

      spqi_cell #(
         .PRIO_BITS (PRIO_BITS),
         .ID_BITS   (ID_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CNT_W'(i) < count_ff),
         .new_id     (new_id),
         .new_prio   (new_prio),
         .match_id   (match_id),
         .left_le    (le_chain[i]),
         .left_id    (l_id),
         .left_prio  (l_prio),
         .right_id   (r_id),
         .right_prio (r_prio),
         .hit_in     (hit_chain[i]),
         .le_out     (le_chain[i+1]),
         .hit_out    (hit_chain[i+1]),
         .id_out     (cell_id[i]),
         .prio_out   (cell_prio[i])
      );
   end

   // Sequencer: next state, row command and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ident_in      = ident_ff;
      hold_id_in    = hold_id_ff;
      hold_prio_in  = hold_prio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;
      ctrl          = '0;
      new_id        = ident_ff;
      new_prio      = req_prio;
      match_id      = req_target;
      hit_seed      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_mode == MODE_POP) begin
               hit_seed = 1'b1;
            end
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_id_in     = '0;
               rsp_prio_in   = '0;
               unique case (req_mode)
                  MODE_ADD: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ctrl.ins  = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                        rsp_id_in = ident_ff;
                        ident_in  = (ident_inc == '0) ? ID_BITS'(1) : ident_inc;
                     end
                  end
                  MODE_REMOVE: begin
                     if (found) begin
                        ctrl.del = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  MODE_CHANGE: begin
                     if (found) begin
                        ctrl.del     = 1'b1;
                        count_in     = count_ff - CNT_W'(1);
                        hold_id_in   = req_target;
                        hold_prio_in = req_prio;
                        rsp_valid_in = 1'b0;
                        state_in     = S_REINSERT;
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  MODE_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        ctrl.del    = 1'b1;
                        count_in    = count_ff - CNT_W'(1);
                        rsp_id_in   = cell_id[0];
                        rsp_prio_in = cell_prio[0];
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         S_REINSERT: begin
            // second pass of a priority change; the row has room
            ctrl.ins      = 1'b1;
            new_id        = hold_id_ff;
            new_prio      = hold_prio_ff;
            count_in      = count_ff + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_id_in     = '0;
            rsp_prio_in   = '0;
            rsp_count_in  = count_in;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ident_ff     <= ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ident_ff     <= ident_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      hold_id_ff    <= hold_id_in;
      hold_prio_ff  <= hold_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Response packing
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[ID_BITS-1:0] = rsp_id_ff;
      rsp_tdata[ID_BITS+PRIO_BITS-1:ID_BITS] = rsp_prio_ff;
      for (int b = 0; b < COUNT_FIELD_BITS; b++) begin
         if (b < CNT_W) begin
            rsp_tdata[ID_BITS+PRIO_BITS+b] = rsp_count_ff[b];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_ident_nonzero: assert property (@(posedge clock) disable iff (reset)
      ident_ff != '0)
      else $error("next id is zero");

   a_reinsert_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REINSERT |-> !rsp_valid_ff)
      else $error("response pending during reinsert pass");

   a_reinsert_one_pass: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REINSERT |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("reinsert pass did not complete");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_mode == MODE_POP && count_ff != '0
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop did not remove an entry");

endmodule

@@ design/spqi_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spqi_cell
// One slot of the sorted row: holds an entry, shifts left or right on command.
// ----------------------------------------------------------------------------
module spqi_cell #(
   parameter int PRIO_BITS = 8,
   parameter int ID_BITS   = 16
) (
   input  logic                   clock,
   input  spqi_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,   // slot holds a live entry
   input  logic [ID_BITS-1:0]     new_id,
   input  logic [PRIO_BITS-1:0]   new_prio,
   input  logic [ID_BITS-1:0]     match_id,
   input  logic                   left_le,    // left neighbor stays on insert
   input  logic [ID_BITS-1:0]     left_id,
   input  logic [PRIO_BITS-1:0]   left_prio,
   input  logic [ID_BITS-1:0]     right_id,
   input  logic [PRIO_BITS-1:0]   right_prio,
   input  logic                   hit_in,     // a hit lies further left
   output logic                   le_out,
   output logic                   hit_out,
   output logic [ID_BITS-1:0]     id_out,
   output logic [PRIO_BITS-1:0]   prio_out
);
   import spqi_pkg::*;

   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;

   // Neighbor flags: sorted prefix and first-hit prefix
   assign le_out  = occupied && (prio_ff <= new_prio);
   assign hit_out = hit_in || (occupied && (id_ff == match_id));

   // Next slot contents
   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      priority if (ctrl.del) begin
         if (hit_out) begin
            id_in   = right_id;
            prio_in = right_prio;
         end
      end else if (ctrl.ins) begin
         if (!le_out) begin
            if (left_le) begin
               id_in   = new_id;
               prio_in = new_prio;
            end else begin
               id_in   = left_id;
               prio_in = left_prio;
            end
         end
      end else begin
         // no command: hold
         id_in   = id_ff;
         prio_in = prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign id_out   = id_ff;
   assign prio_out = prio_ff;

endmodule
